/* hw/rtl/kpe_pkg.sv */
// Package: widths, codes, item and state types of the keepalive probe engine.
`default_nettype none

package kpe_pkg;

	localparam int unsigned OpW       = 2;
	localparam int unsigned TimeW     = 64;
	localparam int unsigned GenW      = 32;
	localparam int unsigned AddrW     = 48;
	localparam int unsigned ByteW     = 8;
	localparam int unsigned LenW      = 16;
	localparam int unsigned IntervalW = 16;
	localparam int unsigned MissW     = 8;
	localparam int unsigned CfgIdxW   = 4;
	localparam int unsigned CfgDataW  = 16;

	localparam logic [OpW-1:0] OP_START = 2'd0;
	localparam logic [OpW-1:0] OP_TICK  = 2'd1;
	localparam logic [OpW-1:0] OP_FRAME = 2'd2;

	localparam logic [ByteW-1:0] FAMILY_KEEPALIVE = 8'h03;
	localparam logic [ByteW-1:0] OPC_ASK          = 8'h51;
	localparam logic [ByteW-1:0] OPC_REPLY        = 8'h52;

	localparam logic [CfgIdxW-1:0] REG_PROBE_INTERVAL = 4'd0;
	localparam logic [CfgIdxW-1:0] REG_MISS_LIMIT     = 4'd1;

	localparam logic [IntervalW-1:0] PROBE_INTERVAL_RST = 16'd1000;
	localparam logic [MissW-1:0]     MISS_LIMIT_RST     = 8'd3;

	typedef struct packed {
		logic [OpW-1:0]   op;
		logic [TimeW-1:0] now_ms;
		logic             session_live;
		logic [GenW-1:0]  session_gen;
		logic [AddrW-1:0] session_peer_addr;
		logic [AddrW-1:0] own_addr;
		logic             parse_ok;
		logic [ByteW-1:0] frame_family;
		logic [ByteW-1:0] frame_opcode;
		logic [LenW-1:0]  frame_payload_len;
		logic [AddrW-1:0] frame_src_addr;
		logic [AddrW-1:0] frame_dst_addr;
	} in_item_t;

	typedef struct packed {
		logic             status;
		logic             action_valid;
		logic             action_is_reply;
		logic [AddrW-1:0] action_dst;
		logic [AddrW-1:0] action_src;
		logic [GenW-1:0]  action_gen;
		logic             disconnected;
		logic             ask_taken;
		logic             reply_taken;
	} out_item_t;

	typedef struct packed {
		logic [CfgIdxW-1:0]  index;
		logic [CfgDataW-1:0] wdata;
	} cfg_wr_t;

	typedef struct packed {
		logic [IntervalW-1:0] probe_interval_ms;
		logic [MissW-1:0]     miss_limit;
	} cfg_t;

	typedef struct packed {
		logic             running;
		logic [AddrW-1:0] peer_addr;
		logic [AddrW-1:0] local_addr;
		logic [GenW-1:0]  latched_gen;
		logic [TimeW-1:0] next_probe_time;
		logic [TimeW-1:0] last_time;
		logic [MissW-1:0] missed_count;
	} eng_state_t;

endpackage

`default_nettype wire

/* hw/rtl/kpe_in_if.sv */
// Interface: input item channel.
`default_nettype none

interface kpe_in_if import kpe_pkg::*; ();
	logic     valid;
	logic     ready;
	in_item_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

`default_nettype wire

/* hw/rtl/kpe_out_if.sv */
// Interface: result item channel.
`default_nettype none

interface kpe_out_if import kpe_pkg::*; ();
	logic      valid;
	logic      ready;
	out_item_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

`default_nettype wire

/* hw/rtl/kpe_cfg_if.sv */
// Interface: configuration write channel.
`default_nettype none

interface kpe_cfg_if import kpe_pkg::*; ();
	logic    valid;
	logic    ready;
	cfg_wr_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

`default_nettype wire

/* hw/rtl/kpe_cfg_regs.sv */
// Configuration registers: probe interval and miss limit.
`default_nettype none

module kpe_cfg_regs import kpe_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	kpe_cfg_if.sink    cfg,
	output cfg_t       cfg_val
);

	cfg_t cfg_q;

	assign cfg.ready = 1'b1;
	assign cfg_val   = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.probe_interval_ms <= PROBE_INTERVAL_RST;
			cfg_q.miss_limit        <= MISS_LIMIT_RST;
		end else if (cfg.valid && cfg.ready) begin
			case (cfg.data.index)
				REG_PROBE_INTERVAL: cfg_q.probe_interval_ms <= cfg.data.wdata[IntervalW-1:0];
				REG_MISS_LIMIT:     cfg_q.miss_limit        <= cfg.data.wdata[MissW-1:0];
				default:            cfg_q                   <= cfg_q;
			endcase
		end
	end

endmodule

`default_nettype wire

/* hw/rtl/kpe_engine.sv */
// Engine: session state registers and the per-item decision logic.
`default_nettype none

module kpe_engine import kpe_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      fire,
	input  in_item_t  item,
	input  cfg_t      cfg_val,
	output out_item_t res
);

	eng_state_t st_q;
	eng_state_t st_d;
	logic [TimeW:0] sum;
	logic           ovf;
	logic           current;
	logic           backwards;
	logic           frame_bad;

	assign sum = {1'b0, item.now_ms} + {{(TimeW + 1 - IntervalW){1'b0}}, cfg_val.probe_interval_ms};
	assign ovf = sum[TimeW];
	assign backwards = item.now_ms < st_q.last_time;
	assign current = st_q.running && item.session_live &&
		(st_q.latched_gen == item.session_gen) &&
		(st_q.peer_addr == item.session_peer_addr) &&
		(st_q.local_addr == item.own_addr);
	assign frame_bad = !item.parse_ok || !st_q.running ||
		(item.frame_family != FAMILY_KEEPALIVE) ||
		((item.frame_opcode != OPC_ASK) && (item.frame_opcode != OPC_REPLY)) ||
		(item.frame_payload_len != '0) ||
		(item.frame_src_addr != st_q.peer_addr) ||
		(item.frame_dst_addr != st_q.local_addr);

	always_comb begin
		st_d = st_q;
		res  = '0;
		case (item.op)
			OP_START: begin
				st_d = '0;
				if (!item.session_live || (item.session_gen == '0) ||
					(item.session_peer_addr == '0) || (item.own_addr == '0) || ovf) begin
					res.status = 1'b1;
				end else begin
					st_d.running         = 1'b1;
					st_d.peer_addr       = item.session_peer_addr;
					st_d.local_addr      = item.own_addr;
					st_d.latched_gen     = item.session_gen;
					st_d.next_probe_time = item.now_ms;
					st_d.last_time       = item.now_ms;
				end
			end
			OP_TICK: begin
				if (backwards) begin
					res.status = 1'b1;
				end else begin
					st_d.last_time = item.now_ms;
					if (st_q.running) begin
						if (!current) begin
							st_d.running         = 1'b0;
							st_d.next_probe_time = '0;
							st_d.missed_count    = '0;
						end else if (item.now_ms >= st_q.next_probe_time) begin
							if ((st_q.missed_count >= cfg_val.miss_limit) || ovf) begin
								st_d.running         = 1'b0;
								st_d.next_probe_time = '0;
								st_d.missed_count    = '0;
								res.disconnected     = 1'b1;
							end else begin
								st_d.missed_count    = MissW'(st_q.missed_count + 1'b1);
								st_d.next_probe_time = sum[TimeW-1:0];
								res.action_valid     = 1'b1;
								res.action_dst       = st_q.peer_addr;
								res.action_src       = st_q.local_addr;
								res.action_gen       = st_q.latched_gen;
							end
						end
					end
				end
			end
			OP_FRAME: begin
				if (backwards) begin
					res.status = 1'b1;
				end else if (st_q.running && !current) begin
					st_d.last_time       = item.now_ms;
					st_d.running         = 1'b0;
					st_d.next_probe_time = '0;
					st_d.missed_count    = '0;
				end else if (frame_bad) begin
					res.status = 1'b1;
				end else if (item.frame_opcode == OPC_ASK) begin
					if (ovf) begin
						res.status = 1'b1;
					end else begin
						st_d.last_time       = item.now_ms;
						st_d.missed_count    = '0;
						st_d.next_probe_time = sum[TimeW-1:0];
						res.ask_taken        = 1'b1;
						res.action_valid     = 1'b1;
						res.action_is_reply  = 1'b1;
						res.action_dst       = st_q.peer_addr;
						res.action_src       = st_q.local_addr;
						res.action_gen       = st_q.latched_gen;
					end
				end else begin
					st_d.last_time     = item.now_ms;
					st_d.missed_count  = '0;
					res.reply_taken    = 1'b1;
				end
			end
			default: begin
				res.status = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '0;
		end else if (fire) begin
			st_q <= st_d;
		end
	end

	a_disc_stops: assert property (@(posedge clk) disable iff (!arst_n)
		fire && res.disconnected |=> !st_q.running)
		else $error("engine still running after disconnect");
	a_action_ok: assert property (@(posedge clk) disable iff (!arst_n)
		fire && res.action_valid |-> !res.status && !res.disconnected)
		else $error("action issued with invalid status or disconnect");
	a_action_runs: assert property (@(posedge clk) disable iff (!arst_n)
		fire && res.action_valid |=> st_q.running)
		else $error("engine stopped after issuing an action");

endmodule

`default_nettype wire

/* hw/rtl/keepalive_probe_engine.sv */
// Top level: keepalive probe engine with input register and result register.
`default_nettype none

// Keepalive probe engine. Items of kind start, tick or received frame enter on req
// and each gives exactly one result on rsp. One item is accepted every clock cycle
// unless rsp stalls with both registers full. Each item passes the input register,
// then the decision logic into the result register; all session state is updated in
// one pass, so consecutive items see each other's effects with no gap. A stalled
// rsp holds one result while one more item waits in the input register. The
// configuration channel is always ready and should be written only while no item is
// in flight; writes to indexes other than the two registers are ignored.
module keepalive_probe_engine import kpe_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	kpe_cfg_if.sink    cfg,
	kpe_in_if.sink     req,
	kpe_out_if.source  rsp
);

	cfg_t      cfg_val;
	in_item_t  item_s1;
	logic      valid_s1;
	out_item_t eng_res;
	out_item_t res_s2;
	logic      res_valid_s2;
	logic      advance;

	assign advance   = valid_s1 && (!res_valid_s2 || rsp.ready);
	assign req.ready = !valid_s1 || advance;
	assign rsp.valid = res_valid_s2;
	assign rsp.data  = res_s2;

	kpe_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.cfg_val (cfg_val)
	);

	kpe_engine u_engine (
		.clk     (clk),
		.arst_n  (arst_n),
		.fire    (advance),
		.item    (item_s1),
		.cfg_val (cfg_val),
		.res     (eng_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			item_s1 <= req.data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_s2 <= 1'b0;
		end else if (!res_valid_s2 || rsp.ready) begin
			res_valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= eng_res;
		end
	end

	a_hold_s1: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && res_valid_s2 && !rsp.ready |=> valid_s1 && $stable(item_s1))
		else $error("input register item lost during output stall");
	a_res_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid_s2) |-> $past(valid_s1))
		else $error("result appeared with no item in the input register");
	a_stall_why: assert property (@(posedge clk) disable iff (!arst_n)
		!req.ready |-> valid_s1 && res_valid_s2 && !rsp.ready)
		else $error("input stalled while a stage was free");

endmodule

`default_nettype wire

/* dv/keepalive_probe_engine_tb.sv */
`timescale 1ns / 100ps
// Testbench: keepalive probe engine driven with directed and random items, results checked in order.
module keepalive_probe_engine_tb import kpe_pkg::*; ();

	localparam logic [OpW-1:0]     OP_UNUSED    = 2'd3;
	localparam logic [CfgIdxW-1:0] REG_UNUSED   = 4'd9;
	localparam logic [TimeW-1:0]   TIME_MAX     = '1;
	localparam int unsigned        DRAIN_CYCLES = 6;

	logic clk;
	logic arst_n;

	kpe_cfg_if cfg ();
	kpe_in_if  req ();
	kpe_out_if rsp ();

	keepalive_probe_engine dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.req    (req),
		.rsp    (rsp)
	);

	in_item_t    queued_items[$];
	out_item_t   due_results[$];
	eng_state_t  model_st;
	cfg_t        model_cfg;
	int unsigned mismatches     = 0;
	int unsigned send_idle_pct  = 0;
	int unsigned recv_stall_pct = 0;
	int unsigned hold_len       = 0;
	int unsigned phase_id       = 0;
	int unsigned seen_phase     = 0;
	int unsigned hold_left      = 0;

	logic             s_live;
	logic [GenW-1:0]  s_gen;
	logic [AddrW-1:0] s_peer;
	logic [AddrW-1:0] s_own;
	logic [TimeW-1:0] gen_time;

	function automatic logic probe_overflows(logic [TimeW-1:0] now);
		logic [TimeW-1:0] iv;
		iv = TimeW'(model_cfg.probe_interval_ms);
		return now > (TIME_MAX - iv);
	endfunction

	function automatic void halt_model();
		model_st.running         = 1'b0;
		model_st.next_probe_time = '0;
		model_st.missed_count    = '0;
	endfunction

	function automatic out_item_t with_action(out_item_t r, logic reply);
		r.action_valid    = 1'b1;
		r.action_is_reply = reply;
		r.action_dst      = model_st.peer_addr;
		r.action_src      = model_st.local_addr;
		r.action_gen      = model_st.latched_gen;
		return r;
	endfunction

	function automatic out_item_t next_keepalive_result(in_item_t it);
		out_item_t        r;
		logic             current;
		logic [TimeW-1:0] iv;
		r  = '0;
		iv = TimeW'(model_cfg.probe_interval_ms);
		current = model_st.running && it.session_live &&
			model_st.latched_gen == it.session_gen &&
			model_st.peer_addr == it.session_peer_addr &&
			model_st.local_addr == it.own_addr;
		case (it.op)
			OP_START: begin
				model_st = '0;
				if (!it.session_live || it.session_gen == '0 || it.session_peer_addr == '0 ||
						it.own_addr == '0 || probe_overflows(it.now_ms)) begin
					r.status = 1'b1;
				end else begin
					model_st.running         = 1'b1;
					model_st.peer_addr       = it.session_peer_addr;
					model_st.local_addr      = it.own_addr;
					model_st.latched_gen     = it.session_gen;
					model_st.next_probe_time = it.now_ms;
					model_st.last_time       = it.now_ms;
				end
			end
			OP_TICK: begin
				if (it.now_ms < model_st.last_time) begin
					r.status = 1'b1;
				end else begin
					model_st.last_time = it.now_ms;
					if (model_st.running) begin
						if (!current) begin
							halt_model();
						end else if (it.now_ms >= model_st.next_probe_time) begin
							if (model_st.missed_count >= model_cfg.miss_limit ||
									probe_overflows(it.now_ms)) begin
								halt_model();
								r.disconnected = 1'b1;
							end else begin
								model_st.missed_count    = MissW'(model_st.missed_count + 1'b1);
								model_st.next_probe_time = it.now_ms + iv;
								r = with_action(r, 1'b0);
							end
						end
					end
				end
			end
			OP_FRAME: begin
				if (it.now_ms < model_st.last_time) begin
					r.status = 1'b1;
				end else if (model_st.running && !current) begin
					model_st.last_time = it.now_ms;
					halt_model();
				end else if (!it.parse_ok || !model_st.running ||
						it.frame_family != FAMILY_KEEPALIVE ||
						(it.frame_opcode != OPC_ASK && it.frame_opcode != OPC_REPLY) ||
						it.frame_payload_len != '0 ||
						it.frame_src_addr != model_st.peer_addr ||
						it.frame_dst_addr != model_st.local_addr) begin
					r.status = 1'b1;
				end else if (it.frame_opcode == OPC_ASK) begin
					if (probe_overflows(it.now_ms)) begin
						r.status = 1'b1;
					end else begin
						model_st.last_time       = it.now_ms;
						model_st.missed_count    = '0;
						model_st.next_probe_time = it.now_ms + iv;
						r.ask_taken = 1'b1;
						r = with_action(r, 1'b1);
					end
				end else begin
					model_st.last_time    = it.now_ms;
					model_st.missed_count = '0;
					r.reply_taken         = 1'b1;
				end
			end
			default: begin
				r.status = 1'b1;
			end
		endcase
		return r;
	endfunction

	task automatic check_field(string name, logic [TimeW-1:0] want, logic [TimeW-1:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
			mismatches++;
		end
	endtask

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin : drive_items
		if (arst_n) begin
			if (req.valid && req.ready)
				due_results.push_back(next_keepalive_result(req.data));
			if (!req.valid || req.ready) begin
				if (queued_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					req.valid <= 1'b1;
					req.data  <= queued_items.pop_front();
				end else begin
					req.valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin : drive_ready
		if (arst_n) begin
			if (phase_id != seen_phase) begin
				seen_phase <= phase_id;
				hold_left  <= hold_len;
				rsp.ready  <= 1'b0;
			end else if (hold_left != 0) begin
				hold_left <= hold_left - 1;
				rsp.ready <= 1'b0;
			end else begin
				rsp.ready <= ($urandom_range(99) >= recv_stall_pct);
			end
		end
	end

	always @(posedge clk) begin : check_results
		out_item_t want;
		if (arst_n && rsp.valid && rsp.ready) begin
			if (due_results.size() == 0) begin
				$display("%0t: unexpected result: expected none, actual %0h", $time, rsp.data);
				mismatches++;
			end else begin
				want = due_results.pop_front();
				check_field("status", TimeW'(want.status), TimeW'(rsp.data.status));
				check_field("action_valid", TimeW'(want.action_valid),
					TimeW'(rsp.data.action_valid));
				check_field("action_is_reply", TimeW'(want.action_is_reply),
					TimeW'(rsp.data.action_is_reply));
				check_field("action_dst", TimeW'(want.action_dst),
					TimeW'(rsp.data.action_dst));
				check_field("action_src", TimeW'(want.action_src),
					TimeW'(rsp.data.action_src));
				check_field("action_gen", TimeW'(want.action_gen),
					TimeW'(rsp.data.action_gen));
				check_field("disconnected", TimeW'(want.disconnected),
					TimeW'(rsp.data.disconnected));
				check_field("ask_taken", TimeW'(want.ask_taken),
					TimeW'(rsp.data.ask_taken));
				check_field("reply_taken", TimeW'(want.reply_taken),
					TimeW'(rsp.data.reply_taken));
			end
		end
	end

	function automatic logic [AddrW-1:0] rand_addr();
		logic [63:0] w;
		w = {$urandom, $urandom};
		return w[AddrW-1:0];
	endfunction

	function automatic in_item_t rand_item();
		logic [351:0] raw;
		for (int i = 0; i < 11; i++)
			raw[i*32 +: 32] = $urandom;
		return raw[$bits(in_item_t)-1:0];
	endfunction

	function automatic in_item_t session_item(logic [OpW-1:0] op);
		in_item_t it;
		it.op                = op;
		it.now_ms            = gen_time;
		it.session_live      = s_live;
		it.session_gen       = s_gen;
		it.session_peer_addr = s_peer;
		it.own_addr          = s_own;
		it.parse_ok          = 1'b1;
		it.frame_family      = FAMILY_KEEPALIVE;
		it.frame_opcode      = OPC_ASK;
		it.frame_payload_len = '0;
		it.frame_src_addr    = s_peer;
		it.frame_dst_addr    = s_own;
		return it;
	endfunction

	function automatic in_item_t item_at(logic [OpW-1:0] op, logic [TimeW-1:0] now);
		gen_time = now;
		return session_item(op);
	endfunction

	function automatic logic [TimeW-1:0] time_step();
		logic [TimeW-1:0] iv;
		iv = TimeW'(model_cfg.probe_interval_ms);
		case ($urandom_range(5))
			0: return '0;
			1: return TimeW'($urandom_range(model_cfg.probe_interval_ms));
			2: return iv;
			3: return iv + TimeW'($urandom_range(3));
			4: return iv >> 1;
			default: return TimeW'($urandom_range(65535));
		endcase
	endfunction

	task automatic advance_time();
		logic [TimeW-1:0] delta;
		delta = time_step();
		if (gen_time + delta >= gen_time)
			gen_time = gen_time + delta;
	endtask

	task automatic new_session(logic well_formed);
		s_live = 1'b1;
		s_gen  = $urandom;
		s_peer = rand_addr();
		s_own  = rand_addr();
		case ($urandom_range(9))
			0: gen_time = {$urandom, $urandom};
			1: gen_time = TIME_MAX - TimeW'($urandom_range(200000));
			default: gen_time = TimeW'($urandom_range(1000000));
		endcase
		if (!well_formed) begin
			case ($urandom_range(4))
				0: s_live = 1'b0;
				1: s_gen = '0;
				2: s_peer = '0;
				3: s_own = '0;
				default: gen_time = TIME_MAX;
			endcase
		end
		queued_items.push_back(session_item(OP_START));
	endtask

	task automatic push_random_items(int unsigned count);
		in_item_t    it;
		int unsigned roll;
		for (int unsigned k = 0; k < count; k++) begin
			roll = $urandom_range(99);
			if (roll < 6) begin
				new_session($urandom_range(99) < 85);
				continue;
			end
			advance_time();
			it = session_item(OP_TICK);
			if (roll < 14) begin
				it = rand_item();
				if ($urandom_range(3) != 0)
					it.now_ms = gen_time;
			end else if (roll < 55) begin
				it.op = OP_TICK;
			end else if (roll < 88) begin
				it.op = OP_FRAME;
				it.frame_opcode = $urandom_range(1) ? OPC_ASK : OPC_REPLY;
				if ($urandom_range(99) < 15) begin
					case ($urandom_range(5))
						0: it.parse_ok = 1'b0;
						1: it.frame_family = ByteW'($urandom_range(255));
						2: it.frame_opcode = ByteW'($urandom_range(255));
						3: it.frame_payload_len = LenW'($urandom_range(65535, 1));
						4: it.frame_src_addr = it.frame_src_addr ^ (48'd1 << $urandom_range(47));
						default: it.frame_dst_addr = it.frame_dst_addr ^ (48'd1 << $urandom_range(47));
					endcase
				end
			end else if (roll < 93) begin
				it.op = $urandom_range(1) ? OP_TICK : OP_FRAME;
				case ($urandom_range(3))
					0: it.session_live = 1'b0;
					1: it.session_gen = it.session_gen ^ (32'd1 << $urandom_range(31));
					2: it.session_peer_addr = it.session_peer_addr ^ (48'd1 << $urandom_range(47));
					default: it.own_addr = it.own_addr ^ (48'd1 << $urandom_range(47));
				endcase
			end else if (roll < 97) begin
				it.op = $urandom_range(1) ? OP_TICK : OP_FRAME;
				it.now_ms = gen_time - TimeW'($urandom_range(1000) + 1);
			end else begin
				it.op = OP_UNUSED;
			end
			queued_items.push_back(it);
		end
	endtask

	task automatic push_directed();
		in_item_t it;
		s_live = 1'b1;
		s_gen  = 32'hFFFF_FFFF;
		s_peer = 48'hFFFF_FFFF_FFFF;
		s_own  = 48'h0000_0000_0001;
		queued_items.push_back(item_at(OP_TICK, 64'd5));
		queued_items.push_back(item_at(OP_FRAME, 64'd6));
		queued_items.push_back(item_at(OP_UNUSED, 64'd7));
		it = item_at(OP_START, 64'd100);
		it.session_gen = '0;
		queued_items.push_back(it);
		it = item_at(OP_START, 64'd100);
		it.session_peer_addr = '0;
		queued_items.push_back(it);
		queued_items.push_back(item_at(OP_START, TIME_MAX));
		queued_items.push_back(item_at(OP_START, 64'd100));
		queued_items.push_back(item_at(OP_TICK, 64'd100));
		queued_items.push_back(item_at(OP_TICK, 64'd50));
		queued_items.push_back(item_at(OP_TICK, 64'd1100));
		it = item_at(OP_FRAME, 64'd1200);
		it.frame_opcode = OPC_REPLY;
		queued_items.push_back(it);
		queued_items.push_back(item_at(OP_FRAME, 64'd1300));
		it = item_at(OP_FRAME, 64'd1310);
		it.parse_ok = 1'b0;
		queued_items.push_back(it);
		it = item_at(OP_FRAME, 64'd1320);
		it.frame_payload_len = 16'hFFFF;
		it.frame_opcode = 8'hFF;
		queued_items.push_back(it);
		it = item_at(OP_FRAME, 64'd1330);
		it.frame_src_addr = 48'hFFFF_FFFF_FFFE;
		queued_items.push_back(it);
		queued_items.push_back(item_at(OP_FRAME, 64'd0));
		for (int k = 0; k < 4; k++)
			queued_items.push_back(item_at(OP_TICK, 64'd2300 + 64'd1000 * k));
		s_gen  = 32'h0000_0001;
		s_peer = 48'h0000_0000_0001;
		s_own  = 48'hFFFF_FFFF_FFFF;
		queued_items.push_back(item_at(OP_START, TIME_MAX - 64'd1000));
		queued_items.push_back(item_at(OP_TICK, TIME_MAX - 64'd1000));
		queued_items.push_back(item_at(OP_TICK, TIME_MAX));
		queued_items.push_back(item_at(OP_START, TIME_MAX - 64'd1000));
		queued_items.push_back(item_at(OP_FRAME, TIME_MAX));
		it = item_at(OP_TICK, TIME_MAX);
		it.session_live = 1'b0;
		queued_items.push_back(it);
	endtask

	task automatic wait_drained();
		do @(negedge clk);
		while (queued_items.size() != 0 || req.valid || due_results.size() != 0);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(logic [CfgIdxW-1:0] index, logic [CfgDataW-1:0] wdata);
		cfg.valid      <= 1'b1;
		cfg.data.index <= index;
		cfg.data.wdata <= wdata;
		do @(posedge clk);
		while (!cfg.ready);
		case (index)
			REG_PROBE_INTERVAL: model_cfg.probe_interval_ms = wdata;
			REG_MISS_LIMIT:     model_cfg.miss_limit = wdata[MissW-1:0];
			default: ;
		endcase
	endtask

	task automatic configure(logic [IntervalW-1:0] iv, logic [MissW-1:0] lim, logic poke_unused);
		logic [CfgDataW-1:0] lim_word;
		lim_word = CfgDataW'($urandom);
		lim_word[MissW-1:0] = lim;
		@(posedge clk);
		if (poke_unused)
			write_reg(REG_UNUSED, CfgDataW'($urandom));
		write_reg(REG_PROBE_INTERVAL, iv);
		write_reg(REG_MISS_LIMIT, lim_word);
		cfg.valid <= 1'b0;
	endtask

	task automatic run_phase(logic [IntervalW-1:0] iv, logic [MissW-1:0] lim, logic poke_unused,
			int unsigned send_pct, int unsigned recv_pct, int unsigned hold,
			int unsigned probe_run, int unsigned count, logic split);
		configure(iv, lim, poke_unused);
		@(negedge clk);
		send_idle_pct  = send_pct;
		recv_stall_pct = recv_pct;
		hold_len       = hold;
		phase_id       = phase_id + 1;
		if (probe_run != 0) begin
			s_live = 1'b1;
			s_gen  = $urandom | 32'd1;
			s_peer = rand_addr();
			s_own  = rand_addr();
			for (int unsigned k = 0; k < probe_run; k++)
				queued_items.push_back(item_at(k == 0 ? OP_START : OP_TICK,
					(k == 0) ? '0 : TimeW'(k - 1)));
		end
		if (split) begin
			push_random_items(count / 2);
			wait_drained();
			push_random_items(count - count / 2);
		end else begin
			push_random_items(count);
		end
		wait_drained();
	endtask

	initial begin : run
		req.valid = 1'b0;
		req.data  = '0;
		cfg.valid = 1'b0;
		cfg.data  = '0;
		rsp.ready = 1'b0;
		model_st  = '0;
		model_cfg.probe_interval_ms = PROBE_INTERVAL_RST;
		model_cfg.miss_limit        = MISS_LIMIT_RST;
		gen_time  = '0;
		arst_n    = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);
		@(negedge clk);
		push_directed();
		wait_drained();
		run_phase(16'd1, 8'd0, 1'b0, 0, 0, 0, 0, 200, 1'b0);
		run_phase(16'd65535, 8'd255, 1'b1, 80, 0, 0, 0, 200, 1'b0);
		run_phase(16'd0, 8'd2, 1'b0, 0, 80, 0, 0, 200, 1'b0);
		run_phase(IntervalW'($urandom_range(50, 1)), MissW'($urandom_range(5, 1)), 1'b0,
			29, 29, 0, 0, 250, 1'b0);
		run_phase(16'd10, 8'd4, 1'b0, 0, 0, 400, 0, 150, 1'b1);
		run_phase(16'd1, 8'd255, 1'b0, 0, 0, 0, 261, 90, 1'b0);
		if (mismatches == 0 && due_results.size() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

	initial begin : watchdog
		#2_000_000;
		$display("CHECKS FAILED");
		$finish;
	end

endmodule
